// ===== rtl/mtfc_pkg.sv =====
// Shared constants and types for the move-to-front id cache.
package mtfc_pkg;

  localparam int CACHE_ENTRIES_DEF = 32;
  localparam int TAG_W             = 16;
  localparam int REC_W             = 15;
  localparam int SLOT_OUT_W        = 5;

  localparam logic [REC_W-1:0] REC_MASK = 15'h7FFF;

  // Tag and valid bit that travel with a slot along the recency list.
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } mtfc_entry_t;

endpackage

// ===== rtl/mtfc_cell.sv =====
// One recency-list position: holds a slot number with its tag, compares and shifts.
module mtfc_cell #(
  parameter int SLOT_W = 5,
  parameter int INDEX  = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      lookup_vld,
  input  logic [mtfc_pkg::TAG_W-1:0] lookup_id,
  input  logic                      found_in,
  output logic                      found_out,
  input  logic [SLOT_W-1:0]         prev_slot,
  input  mtfc_pkg::mtfc_entry_t     prev_entry,
  output logic [SLOT_W-1:0]         slot_r,
  output mtfc_pkg::mtfc_entry_t     entry_r,
  output logic                      match
);
  import mtfc_pkg::*;

  logic             shift;
  logic             valid_r;
  logic [TAG_W-1:0] tag_r;

  assign entry_r   = '{valid: valid_r, tag: tag_r};
  assign match     = valid_r && (tag_r == lookup_id);
  assign found_out = found_in | match;
  // Positions up to and including the matching one move back by one.
  assign shift     = lookup_vld && !found_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= SLOT_W'(INDEX);
      valid_r <= 1'b0;
    end else if (shift) begin
      slot_r  <= prev_slot;
      valid_r <= prev_entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      tag_r <= prev_entry.tag;
    end
  end

endmodule

// ===== rtl/move_to_front_id_cache.sv =====
// Top level: move-to-front id cache built as a row of recency cells.
// Flow: start and in_name_id are registered; the registered lookup is then compared
//   and applied to the cell row while its result is registered onto out_strobe.
// Throughput: one lookup per cycle; busy stays low, the cell row updates on each lookup.
// Reset (synchronous, rst_n low): list holds slots 0..N-1 in order, all entries invalid.
// The receiver cannot stall; each result is shown for exactly one cycle.
module move_to_front_id_cache #(
  parameter int CACHE_ENTRIES = mtfc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [mtfc_pkg::TAG_W-1:0]      in_name_id,
  output logic                            out_strobe,
  output logic                            out_hit,
  output logic [mtfc_pkg::SLOT_OUT_W-1:0] out_slot,
  output logic [mtfc_pkg::REC_W-1:0]      out_record_index
);
  import mtfc_pkg::*;

  localparam int SLOT_W = $clog2(CACHE_ENTRIES);

  logic              lookup_vld_r;
  logic [TAG_W-1:0]  lookup_id_r;

  logic [SLOT_W-1:0] slot_q   [CACHE_ENTRIES];
  mtfc_entry_t       entry_q  [CACHE_ENTRIES];
  logic [CACHE_ENTRIES:0]   found;
  logic [CACHE_ENTRIES-1:0] match_vec;

  logic [SLOT_W-1:0] match_slot;
  logic [SLOT_W-1:0] front_slot;
  mtfc_entry_t       front_entry;
  logic              hit;
  logic [SLOT_W+SLOT_OUT_W-1:0] front_ext;
  logic [SLOT_W+SLOT_OUT_W-1:0] cell0_ext;

  logic                  out_strobe_r;
  logic                  out_hit_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [REC_W-1:0]      out_record_index_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookup_vld_r <= 1'b0;
    end else begin
      lookup_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lookup_id_r <= in_name_id;
    end
  end

  assign found[0] = 1'b0;
  assign hit      = found[CACHE_ENTRIES];

  always_comb begin
    match_slot = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      match_slot = match_slot | (match_vec[i] ? slot_q[i] : '0);
    end
  end

  // On a miss the back entry is retagged and moves to the front.
  assign front_slot  = hit ? match_slot : slot_q[CACHE_ENTRIES-1];
  assign front_entry = '{valid: 1'b1, tag: lookup_id_r};

  genvar g;
  generate
    for (g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
      mtfc_cell #(
        .SLOT_W (SLOT_W),
        .INDEX  (g)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_vld (lookup_vld_r),
        .lookup_id  (lookup_id_r),
        .found_in   (found[g]),
        .found_out  (found[g+1]),
        .prev_slot  ((g == 0) ? front_slot  : slot_q[(g == 0) ? 0 : g-1]),
        .prev_entry ((g == 0) ? front_entry : entry_q[(g == 0) ? 0 : g-1]),
        .slot_r     (slot_q[g]),
        .entry_r    (entry_q[g]),
        .match      (match_vec[g])
      );
    end
  endgenerate

  assign front_ext = {{SLOT_OUT_W{1'b0}}, front_slot};
  assign cell0_ext = {{SLOT_OUT_W{1'b0}}, slot_q[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= lookup_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_vld_r) begin
      out_hit_r          <= hit;
      out_slot_r         <= front_ext[SLOT_OUT_W-1:0];
      out_record_index_r <= hit ? '0 : (lookup_id_r[REC_W-1:0] & REC_MASK);
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_hit          = out_hit_r;
  assign out_slot         = out_slot_r;
  assign out_record_index = out_record_index_r;

  // Tags of valid entries are unique, so at most one cell matches.
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_vld_r |-> $onehot0(match_vec))
    else $error("more than one cell matched the lookup id");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_strobe)
    else $error("accepted lookup produced no result strobe");

  a_hit_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_hit) |-> (out_record_index == '0))
    else $error("record index nonzero on a hit");

  // The reported slot is the one now at the front of the list.
  a_front_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_slot == cell0_ext[SLOT_OUT_W-1:0]))
    else $error("reported slot is not at the front of the list");

endmodule
